// ===== hw/rtl/hmd_pkg.sv =====
// Package for the hour meter with display: shared types, op codes, constants,
// reciprocal constants for the constant dividers and the seven-segment patterns.
// No dependencies.
package hmd_pkg;

    // Field widths.
    localparam int COUNT_W     = 25;
    localparam int TIME_W      = 32;
    localparam int WINDOW_W    = 24;
    localparam int CLICK_W     = 3;
    localparam int OP_W        = 3;
    localparam int SEG_W       = 7;
    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = 2;

    // Register reset values.
    localparam logic [COUNT_W-1:0]  WRAP_LIMIT_RST      = COUNT_W'(32000000);
    localparam logic [COUNT_W-1:0]  ALARM_LEVEL_RST     = COUNT_W'(28800000);
    localparam logic [WINDOW_W-1:0] CLICK_WINDOW_RST    = WINDOW_W'(1000000);
    localparam logic [CLICK_W-1:0]  CLICKS_TO_CLEAR_RST = CLICK_W'(3);

    localparam logic [TIME_W-1:0] ERASED_VALUE = '1;

    // Display scaling: count / TICKS_PER_UNIT is done as a shift by the
    // power-of-two factor and a reciprocal multiply by the odd factor.
    localparam int TICKS_PER_UNIT = 3200;
    localparam int TPU_SHIFT      = 7;
    localparam int TPU_ODD        = TICKS_PER_UNIT / (2 ** TPU_SHIFT);
    localparam int UNIT_K         = 23;
    localparam int UNIT_PROD_W    = 37;
    localparam int UNIT_Q_W       = 14;
    localparam logic [UNIT_PROD_W-1:0] RECIP_UNIT =
        UNIT_PROD_W'((2 ** UNIT_K + TPU_ODD - 1) / TPU_ODD);

    // Save check: count % SAVE_EVERY == 0, via count / SAVE_EVERY.
    localparam int SAVE_EVERY     = 100;
    localparam int SAVE_SHIFT     = 2;
    localparam int SAVE_ODD       = SAVE_EVERY / (2 ** SAVE_SHIFT);
    localparam int SAVE_K         = 28;
    localparam int SAVE_PROD_W    = 47;
    localparam int SAVE_Q_W       = 19;
    localparam logic [SAVE_PROD_W-1:0] RECIP_SAVE =
        SAVE_PROD_W'((2 ** SAVE_K + SAVE_ODD - 1) / SAVE_ODD);

    // Decimal digit extraction on the scaled value.
    localparam int DIG_K       = 24;
    localparam int DIG_PROD_W  = 39;
    localparam int TEN_PROD_W  = 35;
    localparam int TENS_W      = 11;
    localparam logic [DIG_PROD_W-1:0] RECIP_POW10 [DIGIT_COUNT] = '{
        DIG_PROD_W'((2 ** DIG_K + 999) / 1000),
        DIG_PROD_W'((2 ** DIG_K + 99) / 100),
        DIG_PROD_W'((2 ** DIG_K + 9) / 10),
        DIG_PROD_W'(2 ** DIG_K)
    };
    localparam logic [TEN_PROD_W-1:0] RECIP_TEN = TEN_PROD_W'((2 ** DIG_K + 9) / 10);

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CLICK   = 3'd1,
        OP_LONG    = 3'd2,
        OP_RELEASE = 3'd3,
        OP_SCAN    = 3'd4,
        OP_RESTORE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        REG_WRAP_LIMIT      = 2'd0,
        REG_ALARM_LEVEL     = 2'd1,
        REG_CLICK_WINDOW    = 2'd2,
        REG_CLICKS_TO_CLEAR = 2'd3
    } reg_idx_t;

    // Item leaving the control stage: the count after the item and what the
    // datapath still has to do with it.
    typedef struct packed {
        logic [COUNT_W-1:0]     count;
        logic                   scan_load;
        logic [POS_W-1:0]       pos;
        logic [DIGIT_COUNT-1:0] digit_en;
        logic                   save_tick;
        logic                   save_force;
    } stage_t;

    typedef struct packed {
        logic [COUNT_W-1:0]     save_value;
        logic                   save_now;
        logic                   alarm;
        logic [SEG_W-1:0]       segments;
        logic [DIGIT_COUNT-1:0] digit_en;
    } result_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h3F;
        endcase
        return pat;
    endfunction

endpackage

// ===== hw/rtl/hmd_ctrl.sv =====
// Control stage of the hour meter: count, click run, display and scan state.
// Updates its state on every accepted item and hands the item on as a stage_t.
// Depends on hmd_pkg.
module hmd_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [hmd_pkg::OP_W-1:0]      op,
    input  logic [hmd_pkg::TIME_W-1:0]    now_us,
    input  logic [hmd_pkg::TIME_W-1:0]    restore_value,
    input  logic [hmd_pkg::COUNT_W-1:0]   wrap_limit,
    input  logic [hmd_pkg::WINDOW_W-1:0]  click_window_us,
    input  logic [hmd_pkg::CLICK_W-1:0]   clicks_to_clear,
    output hmd_pkg::stage_t               item
);
    import hmd_pkg::*;

    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   display_reg, display_next;
    logic [POS_W-1:0]       scan_pos_reg, scan_pos_next;
    logic [CLICK_W-1:0]     run_reg, run_next;
    logic [TIME_W-1:0]      deadline_reg, deadline_next;
    logic [DIGIT_COUNT-1:0] digit_reg, digit_next;

    logic [COUNT_W:0]       tick_inc;
    logic [CLICK_W-1:0]     run_tmp;
    logic [TIME_W-1:0]      renewed;

    // True when x is strictly later than y in modulo-2^32 time.
    function automatic logic later_than(input logic [TIME_W-1:0] x,
                                        input logic [TIME_W-1:0] y);
        logic [TIME_W-1:0] diff;
        diff = x - y;
        return (diff != '0) && !diff[TIME_W-1];
    endfunction

    always_comb begin
        count_next    = count_reg;
        display_next  = display_reg;
        scan_pos_next = scan_pos_reg;
        run_next      = run_reg;
        deadline_next = deadline_reg;
        digit_next    = digit_reg;
        tick_inc      = {1'b0, count_reg} + (COUNT_W+1)'(1);
        renewed       = now_us + TIME_W'(click_window_us);
        run_tmp       = run_reg;
        item.scan_load  = 1'b0;
        item.pos        = scan_pos_reg;
        item.save_tick  = 1'b0;
        item.save_force = 1'b0;

        case (op_t'(op))
            OP_TICK: begin
                if (later_than(now_us, deadline_reg)) begin
                    deadline_next = '0;
                    run_next      = '0;
                end
                if (tick_inc >= {1'b0, wrap_limit}) begin
                    count_next = '0;
                end else begin
                    count_next = tick_inc[COUNT_W-1:0];
                end
                item.save_tick = 1'b1;
            end
            OP_CLICK: begin
                if (run_reg == '0) begin
                    run_next      = CLICK_W'(1);
                    deadline_next = renewed;
                end else begin
                    if (later_than(deadline_reg, now_us)) begin
                        deadline_next = renewed;
                        run_tmp       = run_reg + CLICK_W'(1);
                    end
                    if (run_tmp >= clicks_to_clear) begin
                        deadline_next = '0;
                        run_tmp       = '0;
                        count_next    = '0;
                    end
                    run_next = run_tmp;
                end
            end
            OP_LONG: begin
                display_next = 1'b1;
            end
            OP_RELEASE: begin
                display_next = 1'b0;
                digit_next   = '0;
            end
            OP_SCAN: begin
                if (display_reg) begin
                    item.scan_load = 1'b1;
                    digit_next     = DIGIT_COUNT'(1) << scan_pos_reg;
                    scan_pos_next  = scan_pos_reg + POS_W'(1);
                end else begin
                    digit_next = '0;
                end
            end
            OP_RESTORE: begin
                if (restore_value == ERASED_VALUE) begin
                    count_next      = '0;
                    item.save_force = 1'b1;
                end else if (restore_value >= TIME_W'(wrap_limit)) begin
                    count_next = '0;
                end else begin
                    count_next = restore_value[COUNT_W-1:0];
                end
            end
            default: begin
            end
        endcase

        item.count    = count_next;
        item.digit_en = digit_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            display_reg  <= 1'b0;
            scan_pos_reg <= '0;
            run_reg      <= '0;
            deadline_reg <= '0;
            digit_reg    <= '0;
        end else if (accept) begin
            count_reg    <= count_next;
            display_reg  <= display_next;
            scan_pos_reg <= scan_pos_next;
            run_reg      <= run_next;
            deadline_reg <= deadline_next;
            digit_reg    <= digit_next;
        end
    end

endmodule

// ===== hw/rtl/hmd_pipe.sv =====
// Result datapath of the hour meter: constant dividers for the display digit and
// the save check, alarm latch, segment hold and the output register.
// Depends on hmd_pkg.
module hmd_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hmd_pkg::stage_t               item,
    input  logic [hmd_pkg::COUNT_W-1:0]   alarm_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hmd_pkg::result_t              result
);
    import hmd_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0]     count;
        logic                   scan_load;
        logic [POS_W-1:0]       pos;
        logic [DIGIT_COUNT-1:0] digit_en;
        logic                   save_tick;
        logic                   save_force;
        logic [UNIT_Q_W-1:0]    q_unit;
        logic [SAVE_Q_W-1:0]    q_save;
        logic                   over_alarm;
    } s2_t;

    typedef struct packed {
        logic                   scan_load;
        logic                   pos_lead;
        logic [DIGIT_COUNT-1:0] digit_en;
        logic                   save_now;
        logic [COUNT_W-1:0]     save_value;
        logic                   over_alarm;
        logic [UNIT_Q_W-1:0]    dig_q;
    } s3_t;

    typedef struct packed {
        logic                   scan_load;
        logic                   pos_lead;
        logic [DIGIT_COUNT-1:0] digit_en;
        logic                   save_now;
        logic [COUNT_W-1:0]     save_value;
        logic                   over_alarm;
        logic [UNIT_Q_W-1:0]    dig_q;
        logic [TENS_W-1:0]      dig_tens;
    } s4_t;

    stage_t  p1_reg;
    s2_t     p2_reg, p2_next;
    s3_t     p3_reg, p3_next;
    s4_t     p4_reg, p4_next;
    result_t out_reg, out_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic free1, free2, free3, free4, free_out;

    logic             alarm_reg, alarm_next;
    logic [SEG_W-1:0] seg_reg, seg_next;

    logic [UNIT_PROD_W-1:0] prod_unit;
    logic [SAVE_PROD_W-1:0] prod_save;
    logic [DIG_PROD_W-1:0]  prod_dig;
    logic [TEN_PROD_W-1:0]  prod_ten;
    logic [COUNT_W-1:0]     save_base;
    logic                   save_hit;
    logic [UNIT_Q_W-1:0]    rem;
    logic [UNIT_Q_W-1:0]    dig_val;
    logic [3:0]             digit;

    // Each slot takes new data when it is empty or its content moves on.
    assign free_out = !out_valid_reg || out_ready;
    assign free4    = !v4_reg || free_out;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_ready = free1;

    // Stage 2: count / TICKS_PER_UNIT, count / SAVE_EVERY, alarm compare.
    always_comb begin
        prod_unit = UNIT_PROD_W'(p1_reg.count[COUNT_W-1:TPU_SHIFT]) * RECIP_UNIT;
        prod_save = SAVE_PROD_W'(p1_reg.count[COUNT_W-1:SAVE_SHIFT]) * RECIP_SAVE;
        p2_next.count      = p1_reg.count;
        p2_next.scan_load  = p1_reg.scan_load;
        p2_next.pos        = p1_reg.pos;
        p2_next.digit_en   = p1_reg.digit_en;
        p2_next.save_tick  = p1_reg.save_tick;
        p2_next.save_force = p1_reg.save_force;
        p2_next.q_unit     = prod_unit[UNIT_K +: UNIT_Q_W];
        p2_next.q_save     = prod_save[SAVE_K +: SAVE_Q_W];
        p2_next.over_alarm = p1_reg.count > alarm_level;
    end

    // Stage 3: pick the power of ten for the scanned position; finish the save check.
    always_comb begin
        prod_dig  = DIG_PROD_W'(p2_reg.q_unit) * RECIP_POW10[p2_reg.pos];
        save_base = COUNT_W'(p2_reg.q_save) * COUNT_W'(SAVE_EVERY);
        save_hit  = p2_reg.save_tick && (save_base == p2_reg.count);
        p3_next.scan_load  = p2_reg.scan_load;
        p3_next.pos_lead   = (p2_reg.pos == '0);
        p3_next.digit_en   = p2_reg.digit_en;
        p3_next.save_now   = p2_reg.save_force || save_hit;
        p3_next.save_value = save_hit ? p2_reg.count : '0;
        p3_next.over_alarm = p2_reg.over_alarm;
        p3_next.dig_q      = prod_dig[DIG_K +: UNIT_Q_W];
    end

    // Stage 4: divide by ten for the remainder.
    always_comb begin
        prod_ten = TEN_PROD_W'(p3_reg.dig_q) * RECIP_TEN;
        p4_next.scan_load  = p3_reg.scan_load;
        p4_next.pos_lead   = p3_reg.pos_lead;
        p4_next.digit_en   = p3_reg.digit_en;
        p4_next.save_now   = p3_reg.save_now;
        p4_next.save_value = p3_reg.save_value;
        p4_next.over_alarm = p3_reg.over_alarm;
        p4_next.dig_q      = p3_reg.dig_q;
        p4_next.dig_tens   = prod_ten[DIG_K +: TENS_W];
    end

    // Output stage: remainder, segment pattern, held segments and alarm latch.
    // The leading digit is not reduced modulo ten; a value above nine shows 0.
    always_comb begin
        rem = p4_reg.dig_q - {p4_reg.dig_tens, 3'b000} - UNIT_Q_W'({p4_reg.dig_tens, 1'b0});
        dig_val = p4_reg.pos_lead ? p4_reg.dig_q : rem;
        digit   = (dig_val > UNIT_Q_W'(9)) ? 4'd0 : dig_val[3:0];
        seg_next   = p4_reg.scan_load ? seg_pattern(digit) : seg_reg;
        alarm_next = alarm_reg || p4_reg.over_alarm;
        out_next.digit_en   = p4_reg.digit_en;
        out_next.segments   = seg_next;
        out_next.alarm      = alarm_next;
        out_next.save_now   = p4_reg.save_now;
        out_next.save_value = p4_reg.save_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            alarm_reg     <= 1'b0;
            seg_reg       <= '0;
        end else begin
            if (free1) begin
                v1_reg <= in_valid;
            end
            if (free2) begin
                v2_reg <= v1_reg;
            end
            if (free3) begin
                v3_reg <= v2_reg;
            end
            if (free4) begin
                v4_reg <= v3_reg;
            end
            if (free_out) begin
                out_valid_reg <= v4_reg;
                if (v4_reg) begin
                    alarm_reg <= alarm_next;
                    seg_reg   <= seg_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free1) begin
            p1_reg <= item;
        end
        if (free2) begin
            p2_reg <= p2_next;
        end
        if (free3) begin
            p3_reg <= p3_next;
        end
        if (free4) begin
            p4_reg <= p4_next;
        end
        if (free_out && v4_reg) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

// ===== hw/rtl/hour_meter_with_display.sv =====
// Top level of the operating-hour meter with a multiplexed seven-segment display.
// Holds the configuration registers and joins the control stage and the datapath.
// Depends on hmd_pkg, hmd_ctrl and hmd_pipe.
// Usage:
//   Each input transfer on the s_ channel carries one event: a tick, a click,
//   a long press, a release, a display scan or a restore (op in s_tuser).
//   Every input transfer produces exactly one result transfer on the m_
//   channel, in order: the lit digit and its segments, the latched alarm, and
//   a save request with the value to store.
//   The block takes one item per cycle unless a held output has filled all
//   its stages: the count, click and display state is updated at the
//   accepting edge, and four more stages run the constant dividers for the
//   display digit and the save check and fill the output.
//   When the receiver holds m_tready low, the result stays in the output
//   register and the pipeline keeps accepting items until all its stages are
//   full; s_tready then falls until the output register drains.
//   Reset (aresetn low, synchronous) clears the count, click run, display,
//   alarm and held segments, empties the pipeline and loads the default
//   register values. Configuration writes are taken at any edge with cfg_wr_en
//   high and should only be issued while no item is in flight.
module hour_meter_with_display (
    input  logic                         aclk,
    input  logic                         aresetn,

    // Configuration write port.
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [hmd_pkg::COUNT_W-1:0]  cfg_wdata,

    // Input channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,  // now_us[31:0], restore_value[63:32]
    input  logic [2:0]                   s_tuser,  // op[2:0]

    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,  // digit_enable[3:0], segments[10:4],
                                                   // alarm[11], save_value[36:12], zero
    output logic                         m_tuser   // save_now[0]
);
    import hmd_pkg::*;

    logic [COUNT_W-1:0]  wrap_limit_reg;
    logic [COUNT_W-1:0]  alarm_level_reg;
    logic [WINDOW_W-1:0] click_window_reg;
    logic [CLICK_W-1:0]  clicks_to_clear_reg;

    logic    s_accept;
    stage_t  item;
    result_t result;

    assign s_accept = s_tvalid && s_tready;

    // Configuration registers; each write takes the low bits of cfg_wdata.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_limit_reg      <= WRAP_LIMIT_RST;
            alarm_level_reg     <= ALARM_LEVEL_RST;
            click_window_reg    <= CLICK_WINDOW_RST;
            clicks_to_clear_reg <= CLICKS_TO_CLEAR_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_WRAP_LIMIT:      wrap_limit_reg      <= cfg_wdata;
                REG_ALARM_LEVEL:     alarm_level_reg     <= cfg_wdata;
                REG_CLICK_WINDOW:    click_window_reg    <= cfg_wdata[WINDOW_W-1:0];
                REG_CLICKS_TO_CLEAR: clicks_to_clear_reg <= cfg_wdata[CLICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // State update for each accepted item.
    hmd_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (s_accept),
        .op              (s_tuser),
        .now_us          (s_tdata[31:0]),
        .restore_value   (s_tdata[63:32]),
        .wrap_limit      (wrap_limit_reg),
        .click_window_us (click_window_reg),
        .clicks_to_clear (clicks_to_clear_reg),
        .item            (item)
    );

    // Digit, save check, alarm and output register.
    hmd_pipe u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .item        (item),
        .alarm_level (alarm_level_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result)
    );

    assign m_tdata = {3'b000, result.save_value, result.alarm,
                      result.segments, result.digit_en};
    assign m_tuser = result.save_now;

    // At most one digit is lit in any result.
    a_digit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[3:0]))
        else $error("more than one digit enabled");

    // A result without a save request carries a zero save value.
    a_save_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[36:12] == '0))
        else $error("save value set without save request");

    // The alarm, once reported, stays on in every later result.
    a_alarm_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11]) |=> m_tdata[11])
        else $error("alarm dropped after latching");

    // The input side only stalls when the output is held by the receiver.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule
